### design/static_bplus_tree_search_top_defines.svh
// assertion macros used by the checker file
`ifndef STATIC_BPLUS_TREE_SEARCH_TOP_DEFINES_SVH
`define STATIC_BPLUS_TREE_SEARCH_TOP_DEFINES_SVH

// check that is switched off while reset is high
`define SBT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error("sbt check failed");

// check that also covers the reset cycles
`define SBT_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("sbt reset check failed");

`endif

### design/sbt_pkg.sv
// types, codes and helpers of the static b+ tree search block
package sbt_pkg;

   localparam int KEY_W    = 64;
   localparam int VAL_W    = 64;
   localparam int INDEX_W  = 11;
   localparam int FANOUT_W = 9;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [FANOUT_W-1:0] FANOUT_RESET = 9'd64;
   localparam logic [FANOUT_W-1:0] FANOUT_MIN   = 9'd2;
   localparam logic [FANOUT_W-1:0] FANOUT_MAX   = 9'd256;

   // register index codes
   localparam logic REG_FANOUT = 1'b0;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_RANGE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_LV,
      ST_LVL,
      ST_MUL,
      ST_RANGE,
      ST_BS,
      ST_BSW,
      ST_FETCH,
      ST_FETCHW,
      ST_RSCAN,
      ST_RSCANW,
      ST_RDONE,
      ST_EMIT,
      ST_EMITW,
      ST_OUT
   } state_type;

   // command from the control path to the geometry unit
   typedef struct packed {
      logic                start;
      logic [FANOUT_W-1:0] fanout;
   } geom_cmd_type;

   function automatic logic [FANOUT_W-1:0] eff_fanout(input logic [FANOUT_W-1:0] f);
      logic [FANOUT_W-1:0] r;
      r = f;
      if (f < FANOUT_MIN) r = FANOUT_MIN;
      if (f > FANOUT_MAX) r = FANOUT_MAX;
      return r;
   endfunction

endpackage

### design/sbt_ifs.sv
// request and response channel interfaces
interface sbt_req_if import sbt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic signed [KEY_W-1:0] key;
   logic signed [KEY_W-1:0] key_high;
   logic [VAL_W-1:0]        value;

   modport source (output valid, action, key, key_high, value, input ready);
   modport sink   (input valid, action, key, key_high, value, output ready);
endinterface

interface sbt_rsp_if import sbt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic               found;
   logic [VAL_W-1:0]   result_value;
   logic               last;
   logic               truncated;
   logic               status;

   modport source (output valid, index, found, result_value, last, truncated, status,
                   input ready);
   modport sink   (input valid, index, found, result_value, last, truncated, status,
                   output ready);
endinterface

### design/sbt_ram.sv
// generic single-port ram with registered read
module sbt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

### design/sbt_geom.sv
// level span unit: fanout powers, one level per cycle through one multiplier
module sbt_geom import sbt_pkg::*; #(
   parameter int LEAF_CAPACITY = 1024,
   parameter int MAX_LEVELS    = 10,
   localparam int SW = $clog2(LEAF_CAPACITY + 1),
   localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
   localparam int PW = SW + FANOUT_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  geom_cmd_type                     cmd,
   output logic                             busy,
   output logic [MAX_LEVELS-1:0][SW-1:0]    span
);
   logic [PW-1:0]       s_ff, s_in;
   logic [FANOUT_W-1:0] f_ff, f_in;
   logic [LW-1:0]       g_ff, g_in;
   logic                busy_ff, busy_in;
   logic                over_ff, over_in;
   logic [MAX_LEVELS-1:0][SW-1:0] span_ff;
   logic                big;
   logic [SW-1:0]       span_val;

   assign big      = over_ff || (s_ff > PW'(LEAF_CAPACITY));
   assign span_val = big ? '0 : s_ff[SW-1:0];

   always_comb begin
      s_in    = s_ff;
      f_in    = f_ff;
      g_in    = g_ff;
      busy_in = busy_ff;
      over_in = over_ff;
      if (cmd.start) begin
         s_in    = PW'(cmd.fanout);
         f_in    = cmd.fanout;
         g_in    = '0;
         busy_in = 1'b1;
         over_in = 1'b0;
      end else if (busy_ff) begin
         over_in = big;
         s_in    = s_ff[SW-1:0] * f_ff;
         g_in    = g_ff + 1'b1;
         if (g_ff == LW'(MAX_LEVELS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         g_ff    <= '0;
         over_ff <= 1'b0;
         s_ff    <= PW'(FANOUT_RESET);
         f_ff    <= FANOUT_RESET;
      end else begin
         busy_ff <= busy_in;
         g_ff    <= g_in;
         over_ff <= over_in;
         s_ff    <= s_in;
         f_ff    <= f_in;
      end
      if (busy_ff && !cmd.start) begin
         span_ff[g_ff] <= span_val;
      end
   end

   assign busy = busy_ff;
   assign span = span_ff;
endmodule

### design/static_bplus_tree_search_top.sv
// top level of the static b+ tree search block
//
// req_bus carries one item per valid/ready handshake: clear, load of a
// key/value pair, lookup of a key, or range query [key, key_high].
// rsp_bus returns one item for clear, load and lookup, and 1 to MAX_RANGE
// items for a range query; last marks the final item of each answer.
// the fanout register sits at byte address 0 of the apb-style port; writing
// it empties the store and reruns the level span unit.
// the block works on one item at a time and drops ready until every result
// item of it has been taken. a load walks the levels in turn and writes a
// level key where the new position starts a group of that level. a lookup
// counts the levels in use, then binary-searches one node per level from the
// top down to the leaf node; each search step waits for one registered read
// of the key memory. a range query then scans the leaf pairs from the found
// position up to key_high and emits each as its own result item.
// after reset, and after each fanout write, the span unit runs through every
// level and ready stays low. a stalled rsp_bus simply holds the result
// item in its output register; nothing is lost.
module static_bplus_tree_search_top import sbt_pkg::*; #(
   parameter int LEAF_CAPACITY = 1024,
   parameter int MAX_LEVELS    = 10,
   parameter int MAX_RANGE     = 64
) (
   input  logic               clock,
   input  logic               reset,
   sbt_req_if.sink            req_bus,
   sbt_rsp_if.source          rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);
   localparam int AW  = $clog2(LEAF_CAPACITY + 1);          // counts and positions
   localparam int CW  = $clog2(LEAF_CAPACITY);              // leaf memory address
   localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int NW  = $clog2(MAX_LEVELS + 1);
   localparam int LS  = LEAF_CAPACITY + MAX_LEVELS;          // level key store depth
   localparam int LSW = $clog2(LS);
   localparam int RW  = $clog2(MAX_RANGE + 1);
   localparam int PW  = AW + FANOUT_W + 1;

   // level l starts at cap - cap/2^l + l; it holds at most cap/2^(l+1) + 1 keys
   function automatic logic [LSW-1:0] level_base(input logic [LW-1:0] l);
      logic [LSW:0] v;
      v = (LSW+1)'(LEAF_CAPACITY) - ((LSW+1)'(LEAF_CAPACITY) >> l) + (LSW+1)'(l);
      return v[LSW-1:0];
   endfunction

   // config register
   logic [FANOUT_W-1:0] fanout_ff, fanout_in;
   logic [FANOUT_W-1:0] fe;
   logic                cfg_wr;
   geom_cmd_type        geom_cmd;
   logic                geom_busy;
   logic [MAX_LEVELS-1:0][AW-1:0] span;

   // store bookkeeping
   logic [AW-1:0]                 n_ff, n_in;
   logic [MAX_LEVELS-1:0][AW-1:0] len_ff, len_in;
   logic [MAX_LEVELS-1:0][AW-1:0] rem_ff, rem_in;

   // sequencer
   state_type               state_ff, state_in;
   action_type              act_ff, act_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] high_ff, high_in;
   logic [NW-1:0]           nlev_ff, nlev_in;
   logic [AW-1:0]           below_ff, below_in;
   logic [LW-1:0]           cur_ff, cur_in;
   logic                    leaf_ff, leaf_in;
   logic                    root_ff, root_in;
   logic [AW-1:0]           node_ff, node_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [AW-1:0]           b_ff, b_in;
   logic [AW-1:0]           lo_ff, lo_in;
   logic [AW-1:0]           hi_ff, hi_in;
   logic [AW-1:0]           mid_ff, mid_in;
   logic [AW-1:0]           start_ff, start_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [RW-1:0]           cnt_ff, cnt_in;
   logic [RW-1:0]           k_ff, k_in;
   logic                    trunc_ff, trunc_in;

   // output register
   logic               rv_ff, rv_in;
   logic [INDEX_W-1:0] ri_ff, ri_in;
   logic               rf_ff, rf_in;
   logic [VAL_W-1:0]   rval_ff, rval_in;
   logic               rl_ff, rl_in;
   logic               rt_ff, rt_in;
   logic               rs_ff, rs_in;

   // memories
   logic               leaf_we;
   logic [CW-1:0]      leaf_addr;
   logic [KEY_W-1:0]   leaf_kw;
   logic [VAL_W-1:0]   leaf_vw;
   logic [KEY_W-1:0]   leaf_key_rd;
   logic [VAL_W-1:0]   leaf_val_rd;
   logic               lvl_we;
   logic [LSW-1:0]     lvl_addr;
   logic [KEY_W-1:0]   lvl_key_rd;

   // scratch
   logic [LW-1:0]      lidx;
   logic [AW-1:0]      sp_w;
   logic [AW-1:0]      len_w;
   logic [AW-1:0]      rem_w;
   logic [AW-1:0]      bound;
   logic [PW-1:0]      sum_w, e_w, b_w;
   logic [AW-1:0]      mid_c;
   logic [LSW:0]       lvl_sum;
   logic [LSW:0]       lvl_wsum;
   logic signed [KEY_W-1:0] cmp_key;
   logic               lvl_go;
   logic [AW-1:0]      emit_pos;

   assign fe     = eff_fanout(fanout_ff);
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FANOUT);
   assign pready = 1'b1;
   assign prdata = CSR_DW'(fanout_ff);

   assign fanout_in       = cfg_wr ? pwdata[FANOUT_W-1:0] : fanout_ff;
   assign geom_cmd.start  = cfg_wr;
   assign geom_cmd.fanout = eff_fanout(pwdata[FANOUT_W-1:0]);

   sbt_geom #(
      .LEAF_CAPACITY (LEAF_CAPACITY),
      .MAX_LEVELS    (MAX_LEVELS)
   ) u_geom (
      .clock (clock),
      .reset (reset),
      .cmd   (geom_cmd),
      .busy  (geom_busy),
      .span  (span)
   );

   sbt_ram #(.WIDTH(KEY_W), .DEPTH(LEAF_CAPACITY)) u_leaf_keys (
      .clock (clock), .we (leaf_we), .addr (leaf_addr), .wdata (leaf_kw),
      .rdata (leaf_key_rd)
   );

   sbt_ram #(.WIDTH(VAL_W), .DEPTH(LEAF_CAPACITY)) u_leaf_values (
      .clock (clock), .we (leaf_we), .addr (leaf_addr), .wdata (leaf_vw),
      .rdata (leaf_val_rd)
   );

   sbt_ram #(.WIDTH(KEY_W), .DEPTH(LS)) u_level_keys (
      .clock (clock), .we (lvl_we), .addr (lvl_addr), .wdata (key_ff),
      .rdata (lvl_key_rd)
   );

   assign req_bus.ready        = (state_ff == ST_IDLE) && !geom_busy;
   assign rsp_bus.valid        = rv_ff;
   assign rsp_bus.index        = ri_ff;
   assign rsp_bus.found        = rf_ff;
   assign rsp_bus.result_value = rval_ff;
   assign rsp_bus.last         = rl_ff;
   assign rsp_bus.truncated    = rt_ff;
   assign rsp_bus.status       = rs_ff;

   // one level slot is looked at per cycle: the level count walk or the current level
   assign lidx  = (state_ff == ST_LVL) ? nlev_ff[LW-1:0] : cur_ff;
   assign sp_w  = span[lidx];
   assign len_w = len_ff[lidx];
   assign rem_w = rem_ff[lidx];

   // shared key compare operand: leaf or level memory data
   assign cmp_key  = leaf_ff ? leaf_key_rd : lvl_key_rd;
   assign mid_c    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lvl_sum  = {1'b0, level_base(cur_ff)} + (LSW+1)'(mid_c);
   assign lvl_wsum = {1'b0, level_base(cur_ff)} + (LSW+1)'(len_w);
   assign bound    = leaf_ff ? n_ff : len_w;
   assign sum_w    = prod_ff + PW'(fe);
   assign lvl_go   = (nlev_ff < NW'(MAX_LEVELS)) && (PW'(below_ff) > PW'(fe))
                     && (sp_w != '0);
   assign emit_pos = start_ff + AW'(k_ff);

   always_comb begin
      n_in     = n_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      state_in = state_ff;
      act_in   = act_ff;
      key_in   = key_ff;
      high_in  = high_ff;
      nlev_in  = nlev_ff;
      below_in = below_ff;
      cur_in   = cur_ff;
      leaf_in  = leaf_ff;
      root_in  = root_ff;
      node_in  = node_ff;
      prod_in  = prod_ff;
      b_in     = b_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      trunc_in = trunc_ff;
      rv_in    = rv_ff;
      ri_in    = ri_ff;
      rf_in    = rf_ff;
      rval_in  = rval_ff;
      rl_in    = rl_ff;
      rt_in    = rt_ff;
      rs_in    = rs_ff;
      leaf_we   = 1'b0;
      leaf_addr = pos_ff[CW-1:0];
      leaf_kw   = req_bus.key;
      leaf_vw   = req_bus.value;
      lvl_we    = 1'b0;
      lvl_addr  = lvl_sum[LSW-1:0];
      e_w       = '0;
      b_w       = '0;

      case (state_ff)
         ST_IDLE: begin
            leaf_addr = n_ff[CW-1:0];
            if (req_bus.valid && req_bus.ready) begin
               act_in  = action_type'(req_bus.action);
               key_in  = req_bus.key;
               high_in = req_bus.key_high;
               // default result shape: empty, last
               ri_in   = '0;
               rf_in   = 1'b0;
               rval_in = '0;
               rl_in   = 1'b1;
               rt_in   = 1'b0;
               rs_in   = 1'b0;
               case (action_type'(req_bus.action))
                  ACT_CLEAR: begin
                     n_in     = '0;
                     len_in   = '0;
                     rem_in   = '0;
                     rv_in    = 1'b1;
                     state_in = ST_OUT;
                  end
                  ACT_LOAD: begin
                     if (n_ff >= AW'(LEAF_CAPACITY)) begin
                        // store full: refused
                        ri_in    = INDEX_W'(n_ff);
                        rs_in    = 1'b1;
                        rv_in    = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        leaf_we  = 1'b1;
                        cur_in   = '0;
                        state_in = ST_LOAD_LV;
                     end
                  end
                  default: begin
                     nlev_in  = '0;
                     below_in = n_ff;
                     state_in = ST_LVL;
                  end
               endcase
            end
         end

         ST_LOAD_LV: begin
            // a level records the key when the new position starts one of its groups
            lvl_addr = lvl_wsum[LSW-1:0];
            if (sp_w != '0) begin
               if (rem_w == '0) begin
                  lvl_we         = 1'b1;
                  len_in[cur_ff] = len_w + 1'b1;
               end
               rem_in[cur_ff] = ((rem_w + 1'b1) == sp_w) ? '0 : rem_w + 1'b1;
            end
            if (cur_ff == LW'(MAX_LEVELS - 1)) begin
               n_in     = n_ff + 1'b1;
               ri_in    = INDEX_W'(n_ff);
               rv_in    = 1'b1;
               state_in = ST_OUT;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         ST_LVL: begin
            if (lvl_go) begin
               below_in = len_w;
               nlev_in  = nlev_ff + 1'b1;
            end else begin
               if (nlev_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  leaf_in = 1'b0;
                  cur_in  = LW'(nlev_ff - 1'b1);
               end
               root_in  = 1'b1;
               node_in  = '0;
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            prod_in  = PW'(node_ff) * PW'(fe);
            state_in = ST_RANGE;
         end

         ST_RANGE: begin
            if (root_ff) begin
               e_w = PW'(bound);
               b_w = '0;
            end else begin
               e_w = (sum_w < PW'(bound)) ? sum_w : PW'(bound);
               b_w = prod_ff;
            end
            if (b_w > e_w) begin
               b_w = e_w;
            end
            b_in     = b_w[AW-1:0];
            lo_in    = b_w[AW-1:0];
            hi_in    = e_w[AW-1:0];
            state_in = ST_BS;
         end

         ST_BS: begin
            leaf_addr = mid_c[CW-1:0];
            if (lo_ff < hi_ff) begin
               mid_in   = mid_c;
               state_in = ST_BSW;
            end else if (leaf_ff) begin
               pos_in = lo_ff;
               if (act_ff == ACT_LOOKUP) begin
                  state_in = ST_FETCH;
               end else begin
                  start_in = lo_ff;
                  cnt_in   = '0;
                  trunc_in = 1'b0;
                  state_in = ST_RSCAN;
               end
            end else begin
               // step back one node unless at the node's first key
               node_in = (lo_ff > b_ff) ? lo_ff - 1'b1 : b_ff;
               root_in = 1'b0;
               if (cur_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  cur_in = cur_ff - 1'b1;
               end
               state_in = ST_MUL;
            end
         end

         ST_BSW: begin
            if (cmp_key < key_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_BS;
         end

         ST_FETCH: begin
            if (pos_ff < n_ff) begin
               state_in = ST_FETCHW;
            end else begin
               ri_in    = INDEX_W'(pos_ff);
               rv_in    = 1'b1;
               state_in = ST_OUT;
            end
         end

         ST_FETCHW: begin
            ri_in = INDEX_W'(pos_ff);
            if ($signed(leaf_key_rd) == key_ff) begin
               rf_in   = 1'b1;
               rval_in = leaf_val_rd;
            end
            rv_in    = 1'b1;
            state_in = ST_OUT;
         end

         ST_RSCAN: begin
            state_in = (pos_ff < n_ff) ? ST_RSCANW : ST_RDONE;
         end

         ST_RSCANW: begin
            if (!($signed(leaf_key_rd) > high_ff)) begin
               if (cnt_ff == RW'(MAX_RANGE)) begin
                  trunc_in = 1'b1;
                  state_in = ST_RDONE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_RSCAN;
               end
            end else begin
               state_in = ST_RDONE;
            end
         end

         ST_RDONE: begin
            k_in = '0;
            if (cnt_ff == '0) begin
               ri_in    = INDEX_W'(start_ff);
               rv_in    = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            leaf_addr = emit_pos[CW-1:0];
            state_in  = ST_EMITW;
         end

         ST_EMITW: begin
            ri_in    = INDEX_W'(emit_pos);
            rf_in    = 1'b1;
            rval_in  = leaf_val_rd;
            rl_in    = ((k_ff + 1'b1) == cnt_ff);
            rt_in    = trunc_ff;
            rs_in    = 1'b0;
            rv_in    = 1'b1;
            k_in     = k_ff + 1'b1;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (rsp_bus.ready) begin
               rv_in = 1'b0;
               if ((act_ff == ACT_RANGE) && (cnt_ff != '0) && (k_ff != cnt_ff)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a fanout write empties the store
      if (cfg_wr) begin
         n_in   = '0;
         len_in = '0;
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fanout_ff <= FANOUT_RESET;
         n_ff      <= '0;
         len_ff    <= '0;
         rem_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fanout_ff <= fanout_in;
         n_ff      <= n_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      key_ff   <= key_in;
      high_ff  <= high_in;
      nlev_ff  <= nlev_in;
      below_ff <= below_in;
      cur_ff   <= cur_in;
      leaf_ff  <= leaf_in;
      root_ff  <= root_in;
      node_ff  <= node_in;
      prod_ff  <= prod_in;
      b_ff     <= b_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      start_ff <= start_in;
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      trunc_ff <= trunc_in;
      ri_ff    <= ri_in;
      rf_ff    <= rf_in;
      rval_ff  <= rval_in;
      rl_ff    <= rl_in;
      rt_ff    <= rt_in;
      rs_ff    <= rs_in;
   end
endmodule

### design/sbt_checker.sv
// port-level checks of the search block and their binding
`include "static_bplus_tree_search_top_defines.svh"

module sbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_index,
   input logic        rsp_found,
   input logic [63:0] rsp_result_value,
   input logic        rsp_last,
   input logic        rsp_status
);
   // after reset the span unit runs first, nothing is shown
   `SBT_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid && !req_ready)
   // one item at a time: no new item while a result waits
   `SBT_ASSERT(a_one_at_a_time, !(req_ready && rsp_valid))
   // a refused load is a single, not-found answer
   `SBT_ASSERT(a_refused_single, rsp_valid && rsp_status |-> rsp_last && !rsp_found)
   // no value without a match
   `SBT_ASSERT(a_value_zero, rsp_valid && !rsp_found |-> rsp_result_value == 64'd0)
   // a stalled result item holds
   `SBT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
endmodule

bind static_bplus_tree_search_top sbt_checker u_sbt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_index        (rsp_bus.index),
   .rsp_found        (rsp_bus.found),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_last         (rsp_bus.last),
   .rsp_status       (rsp_bus.status)
);

### test/tb_static_bplus_tree_search_top.sv
// testbench of the static b+ tree search block: directed and random items checked against a predictor
`timescale 1ns / 100ps

module tb_static_bplus_tree_search_top;
   import sbt_pkg::*;

   localparam int LEAF_CAP  = 1024;
   localparam int LEVEL_CNT = 10;
   localparam int RANGE_CAP = 64;
   localparam int LEVEL_MEM = LEAF_CAP + LEVEL_CNT;

   // one expected result item
   typedef struct {
      logic [INDEX_W-1:0] index;
      logic               found;
      logic [VAL_W-1:0]   result_value;
      logic               last;
      logic               truncated;
      logic               status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [CSR_AW-1:0] paddr   = '0;
   logic [CSR_DW-1:0] pwdata  = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   sbt_req_if req_bus ();
   sbt_rsp_if rsp_bus ();

   static_bplus_tree_search_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // idling controls, in percent of cycles
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic hold_rsp     = 1'b0;
   logic rsp_ready_q  = 1'b0;
   int  mismatches    = 0;

   assign rsp_bus.ready = rsp_ready_q;

   // predictor copy of the index
   logic signed [KEY_W-1:0] tree_leaf_key [LEAF_CAP];
   logic [VAL_W-1:0]        tree_leaf_val [LEAF_CAP];
   logic signed [KEY_W-1:0] tree_level_key [LEVEL_MEM];
   int  tree_level_len [LEVEL_CNT];
   int  tree_count = 0;
   logic [FANOUT_W-1:0] tree_fanout = FANOUT_RESET;
   int  geo_span [LEVEL_CNT];
   int  geo_base [LEVEL_CNT];

   answer_type pending_answers [$];

   // out-of-range fanout values saturate
   function automatic int active_fanout();
      if (tree_fanout < 2) return 2;
      if (tree_fanout > 256) return 256;
      return tree_fanout;
   endfunction

   // keys covered per entry of each level and where each level starts in the store
   function automatic void compute_geometry(input int f);
      int s;
      int off;
      s = f;
      off = 0;
      for (int l = 0; l < LEVEL_CNT; l++) begin
         geo_base[l] = off;
         if (s > LEAF_CAP) begin
            geo_span[l] = 0;
         end else begin
            geo_span[l] = s;
            off += (LEAF_CAP + s - 1) / s;
            s *= f;
         end
      end
   endfunction

   function automatic logic signed [KEY_W-1:0] level_key_at(input int idx);
      return (idx < LEVEL_MEM) ? tree_level_key[idx] : '0;
   endfunction

   function automatic logic signed [KEY_W-1:0] leaf_key_at(input int idx);
      return (idx < LEAF_CAP) ? tree_leaf_key[idx] : '0;
   endfunction

   function automatic void empty_tree();
      tree_count = 0;
      foreach (tree_level_len[l]) tree_level_len[l] = 0;
   endfunction

   // descend the kept levels, stepping back one node each time, then search the leaf node
   function automatic int lower_pos(input logic signed [KEY_W-1:0] k);
      int f, n, below, node, b, e, lo, hi, mid, nlev, len;
      f = active_fanout();
      compute_geometry(f);
      n = tree_count;
      below = n;
      node = 0;
      nlev = 0;
      while (nlev < LEVEL_CNT && below > f && geo_span[nlev] != 0) begin
         below = tree_level_len[nlev];
         nlev++;
      end
      for (int i = nlev; i > 0; i--) begin
         len = tree_level_len[i-1];
         if (i == nlev) begin
            b = 0;
            e = len;
         end else begin
            b = node * f;
            e = (b + f < len) ? b + f : len;
            if (b > e) b = e;
         end
         lo = b;
         hi = e;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (level_key_at(geo_base[i-1] + mid) < k) lo = mid + 1;
            else hi = mid;
         end
         node = (lo > b) ? lo - 1 : b;
      end
      if (nlev == 0) begin
         b = 0;
         e = n;
      end else begin
         b = node * f;
         e = (b + f < n) ? b + f : n;
         if (b > e) b = e;
      end
      lo = b;
      hi = e;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (leaf_key_at(mid) < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void push_answer(input int idx, input logic fnd, input logic [VAL_W-1:0] v,
                                       input logic lst, input logic trc, input logic sts);
      answer_type a;
      a.index        = idx[INDEX_W-1:0];
      a.found        = fnd;
      a.result_value = v;
      a.last         = lst;
      a.truncated    = trc;
      a.status       = sts;
      pending_answers = {pending_answers, a};
   endfunction

   // update the predictor for one accepted item and queue its answers
   function automatic void predict_answers(input action_type act, input logic signed [KEY_W-1:0] k,
                                           input logic signed [KEY_W-1:0] kh,
                                           input logic [VAL_W-1:0] v);
      int p, idx, start, cnt;
      logic trc;
      case (act)
         ACT_CLEAR: begin
            empty_tree();
            push_answer(0, 1'b0, '0, 1'b1, 1'b0, 1'b0);
         end
         ACT_LOAD: begin
            p = tree_count;
            if (p >= LEAF_CAP) begin
               push_answer(p, 1'b0, '0, 1'b1, 1'b0, 1'b1);
            end else begin
               tree_leaf_key[p] = k;
               tree_leaf_val[p] = v;
               compute_geometry(active_fanout());
               for (int l = 0; l < LEVEL_CNT; l++) begin
                  if (geo_span[l] != 0 && p % geo_span[l] == 0) begin
                     idx = geo_base[l] + p / geo_span[l];
                     if (idx < LEVEL_MEM) tree_level_key[idx] = k;
                     tree_level_len[l] = p / geo_span[l] + 1;
                  end
               end
               tree_count = p + 1;
               push_answer(p, 1'b0, '0, 1'b1, 1'b0, 1'b0);
            end
         end
         ACT_LOOKUP: begin
            idx = lower_pos(k);
            if (idx < tree_count && leaf_key_at(idx) == k)
               push_answer(idx, 1'b1, tree_leaf_val[idx], 1'b1, 1'b0, 1'b0);
            else
               push_answer(idx, 1'b0, '0, 1'b1, 1'b0, 1'b0);
         end
         default: begin
            start = lower_pos(k);
            idx = start;
            cnt = 0;
            while (idx < tree_count && cnt < RANGE_CAP && !(kh < leaf_key_at(idx))) begin
               idx++;
               cnt++;
            end
            if (cnt == 0) begin
               push_answer(start, 1'b0, '0, 1'b1, 1'b0, 1'b0);
            end else begin
               trc = (idx < tree_count && !(kh < leaf_key_at(idx)));
               for (int j = 0; j < cnt; j++)
                  push_answer(start + j, 1'b1, tree_leaf_val[start + j], j == cnt - 1, trc, 1'b0);
            end
         end
      endcase
   endfunction

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      rsp_ready_q <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: index %0d value %h", rsp_bus.index,
                        rsp_bus.result_value);
         end else begin
            a = pending_answers.pop_front();
            if (rsp_bus.index !== a.index || rsp_bus.found !== a.found ||
                rsp_bus.result_value !== a.result_value || rsp_bus.last !== a.last ||
                rsp_bus.truncated !== a.truncated || rsp_bus.status !== a.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected idx %0d fnd %b val %h lst %b trc %b sts %b, got idx %0d fnd %b val %h lst %b trc %b sts %b",
                           a.index, a.found, a.result_value, a.last, a.truncated, a.status,
                           rsp_bus.index, rsp_bus.found, rsp_bus.result_value, rsp_bus.last,
                           rsp_bus.truncated, rsp_bus.status);
            end
         end
      end
   end

   // send one item; called and returns at a falling edge
   task automatic send_request(input action_type act, input logic signed [KEY_W-1:0] k,
                               input logic signed [KEY_W-1:0] kh, input logic [VAL_W-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.action   = act;
      req_bus.key      = k;
      req_bus.key_high = kh;
      req_bus.value    = v;
      do @(posedge clock); while (!req_bus.ready);
      predict_answers(act, k, kh, v);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // sender pause until every expected result has arrived
   task automatic wait_drained();
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // apb write of the fanout register, only with the block idle
   task automatic write_fanout(input logic [FANOUT_W-1:0] f);
      wait_drained();
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = CSR_AW'(4 * REG_FANOUT);
      pwdata  = CSR_DW'(f);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tree_fanout = f;
      empty_tree();
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic logic signed [KEY_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // ascending keys from a random start, with repeats and the odd out-of-order key
   task automatic load_sorted(input int n, input logic signed [KEY_W-1:0] start, input int step_max);
      logic signed [KEY_W-1:0] k;
      k = start;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(49) == 0)
            send_request(ACT_LOAD, k - $urandom_range(1, 1000), '0, random_word());
         else
            send_request(ACT_LOAD, k, '0, random_word());
         k += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, step_max);
      end
   endtask

   // lookups and ranges aimed mostly at stored keys
   task automatic random_queries(input int n);
      logic signed [KEY_W-1:0] k, kh;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(9);
         if (tree_count == 0 || pick == 0) begin
            k = random_word();
            kh = random_word();
         end else begin
            k = tree_leaf_key[$urandom_range(tree_count - 1)];
            if (pick == 1) k += 1;
            if (pick == 2) k -= 1;
            kh = tree_leaf_key[$urandom_range(tree_count - 1)];
            if (pick > 7) kh = k + $urandom_range(0, 5000);
         end
         if ($urandom_range(1)) send_request(ACT_LOOKUP, k, '0, random_word());
         else send_request(ACT_RANGE, k, kh, random_word());
      end
   endtask

   // extremes, every action, empty store, duplicates, misses
   task automatic test_directed();
      logic signed [KEY_W-1:0] kmin, kmax;
      kmin = {1'b1, 63'd0};
      kmax = {1'b0, {63{1'b1}}};
      send_request(ACT_CLEAR, '0, '0, '0);
      send_request(ACT_LOOKUP, '0, '0, '0);
      send_request(ACT_RANGE, kmin, kmax, '0);
      send_request(ACT_LOAD, kmin, '0, '0);
      send_request(ACT_LOAD, -1, '0, '1);
      send_request(ACT_LOAD, 0, '0, 64'h5555_aaaa_5555_aaaa);
      send_request(ACT_LOAD, 0, '0, 64'haaaa_5555_aaaa_5555);
      send_request(ACT_LOAD, kmax, '0, 64'h1);
      send_request(ACT_LOOKUP, kmin, '0, '0);
      send_request(ACT_LOOKUP, 0, '0, '0);
      send_request(ACT_LOOKUP, 5, '0, '0);
      send_request(ACT_LOOKUP, kmax, '0, '0);
      send_request(ACT_RANGE, kmin, kmax, '0);
      send_request(ACT_RANGE, 1, -1, '0);
      send_request(ACT_RANGE, kmax, kmax, '0);
      send_request(ACT_RANGE, 1, 2, '0);
      // out-of-order key is taken as is
      send_request(ACT_LOAD, -100, '0, 64'h77);
      send_request(ACT_LOOKUP, -100, '0, '0);
      send_request(ACT_CLEAR, '0, '0, '0);
      send_request(ACT_LOOKUP, kmax, '0, '0);
   endtask

   // several fanouts, the saturating ones among them, each with a fresh tree
   task automatic test_fanout_sweep();
      logic [FANOUT_W-1:0] settings [9] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd64, 9'd256,
                                            9'd257, 9'd511};
      foreach (settings[s]) begin
         write_fanout(settings[s]);
         load_sorted($urandom_range(2, 8), random_word() >>> 2, 1 << $urandom_range(1, 30));
         random_queries(4);
         // a range over every key
         send_request(ACT_RANGE, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, '0);
      end
   endtask

   // the smallest fanout gives a deep tree; a range over all of it gets cut
   task automatic test_deep_tree();
      write_fanout(9'd2);
      for (int i = 0; i < 72; i++)
         send_request(ACT_LOAD, 64'(3 * i - 1500), '0, random_word());
      random_queries(6);
      send_request(ACT_LOOKUP, 64'(3 * 71 - 1500), '0, '0);
      send_request(ACT_RANGE, 64'(-1600), 64'd100000, '0);
      send_request(ACT_RANGE, 64'(3 * 60 - 1500), 64'd100000, '0);
      send_request(ACT_CLEAR, '0, '0, '0);
   endtask

   // long receiver hold-off while the sender keeps offering items
   task automatic test_backpressure();
      write_fanout(9'd5);
      load_sorted(20, -64'sd20000, 50);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_queries(20);
      join
      wait_drained();
   endtask

   // rounds of clear, well-formed loads and queries, with some noise
   task automatic test_random(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         if ($urandom_range(3) == 0) write_fanout(FANOUT_W'($urandom_range(2, 12)));
         send_request(ACT_CLEAR, '0, '0, '0);
         load_sorted($urandom_range(5, 20), random_word() >>> 2, 1 << $urandom_range(1, 30));
         random_queries($urandom_range(5, 12));
      end
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.action   = ACT_CLEAR;
      req_bus.key      = '0;
      req_bus.key_high = '0;
      req_bus.value    = '0;
      empty_tree();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 75;
      test_directed();
      test_fanout_sweep();
      test_random(1);
      send_idle_pct = 75;
      recv_idle_pct = 37;
      test_backpressure();
      test_random(1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_deep_tree();
      test_random(1);
      write_fanout(9'd64);

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
